### rtl/limit_order_book_matcher_assert.svh
// assertion macros shared by the order book rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// same-cycle implication
`define LOBM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("order book assertion failed");

// next-cycle implication
`define LOBM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("order book assertion failed");

`endif

### rtl/lobm_pkg.sv
// shared types and constants of the order book matcher
// no dependencies
package lobm_pkg;

	localparam int ID_W        = 10;
	localparam int PRICE_W     = 8;
	localparam int QTY_W       = 32;
	localparam int KIND_W      = 3;
	localparam int OP_W        = 2;
	// price width carried on the level cell chain, covers the largest book
	localparam int LVL_PRICE_W = 16;
	localparam int CELL_LEVELS = 16;
	localparam int CELL_LW     = 4;

	localparam logic [OP_W-1:0] OP_BUY    = 2'd0;
	localparam logic [OP_W-1:0] OP_SELL   = 2'd1;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
	localparam logic [OP_W-1:0] OP_BAD    = 2'd3;

	localparam logic [KIND_W-1:0] EV_FILL      = 3'd0;
	localparam logic [KIND_W-1:0] EV_RESTED    = 3'd1;
	localparam logic [KIND_W-1:0] EV_DONE      = 3'd2;
	localparam logic [KIND_W-1:0] EV_CANCELLED = 3'd3;
	localparam logic [KIND_W-1:0] EV_UNKNOWN   = 3'd4;
	localparam logic [KIND_W-1:0] EV_DUPLICATE = 3'd5;
	localparam logic [KIND_W-1:0] EV_CAP       = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [ID_W-1:0]    order_id;
		logic [PRICE_W-1:0] limit_price;
		logic               is_market;
		logic [QTY_W-1:0]   order_quantity;
	} order_t;

	typedef struct packed {
		logic [KIND_W-1:0]  event_kind;
		logic [ID_W-1:0]    maker_id;
		logic [PRICE_W-1:0] trade_price;
		logic [QTY_W-1:0]   trade_quantity;
		logic [QTY_W-1:0]   remaining_quantity;
		logic               last_event;
	} event_t;

	// broadcast write of one level flag
	typedef struct packed {
		logic                   en;
		logic                   side;
		logic [LVL_PRICE_W-1:0] price;
		logic                   val;
	} flag_wr_t;

	// best levels handed along the cell chain
	typedef struct packed {
		logic                   buy_found;
		logic [LVL_PRICE_W-1:0] buy_price;
		logic                   sell_found;
		logic [LVL_PRICE_W-1:0] sell_price;
	} best_t;

endpackage

### rtl/lobm_stream_if.sv
// valid/ready channel carrying one payload beat
// no dependencies
interface lobm_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/limit_order_book_matcher.sv
// order book matcher top level: sequencer, slot and level memories, level cell chain
// depends on lobm_pkg, lobm_stream_if, lobm_ram, lobm_level_cell and the assertion header
//
// orders: sink channel, one beat per buy, sell or cancel. events: source channel,
// one beat per result; the last beat of an input carries last_event.
// an input is taken only while the sequencer is idle. each best-price lookup
// waits until the level flags have rippled through a chain of NCELLS cells
// (PRICE_LEVELS/16, rounded up), the best price moving one cell a cycle; each
// fill reads the level and then its head order, and a used-up resting order is
// unlinked through the slot memory, which has one write and one read port; a
// cancel of a live id unlinks it the same way. the closing result
// sits in the event register while the next order is already accepted.
// after reset the block sweeps the slot memory to clear the live bits, holding
// orders.ready low throughout; the level flags clear at once.
// a stalled event register holds the sequencer in its emit step.
`include "limit_order_book_matcher_assert.svh"
module limit_order_book_matcher import lobm_pkg::*; #(
	parameter int ORDER_SLOTS  = 1024,
	parameter int PRICE_LEVELS = 256,
	parameter int MAX_FILLS    = 63
) (
	input logic           clk,
	input logic           arst_n,
	lobm_stream_if.sink   orders,
	lobm_stream_if.source events
);
	localparam int SW     = $clog2(ORDER_SLOTS);
	localparam int PW     = $clog2(PRICE_LEVELS);
	localparam int NLEVELS = 2 * PRICE_LEVELS;
	localparam int LW     = $clog2(NLEVELS);
	localparam int NCELLS = (PRICE_LEVELS + CELL_LEVELS - 1) / CELL_LEVELS;
	localparam int CIW    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
	localparam int WW     = $clog2(NCELLS + 1);
	localparam int FW     = $clog2(MAX_FILLS + 1);

	// one order slot record, live bit included so the clearing sweep resets it
	typedef struct packed {
		logic             live;
		logic             side;
		logic [PW-1:0]    price;
		logic [QTY_W-1:0] qty;
		logic [SW-1:0]    next;
		logic [SW-1:0]    prev;
	} slot_rec_t;

	typedef struct packed {
		logic [SW-1:0] head;
		logic [SW-1:0] tail;
	} lvl_rec_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_SELF_CHK, ST_SEARCH, ST_MATCH_LVL, ST_MATCH_HEAD,
		ST_MATCH_TRADE, ST_UL_LVL, ST_UL_CHK, ST_UL_P, ST_UL_N, ST_UL_SELF,
		ST_CLOSE, ST_REST, ST_REST_LVL, ST_REST_T, ST_REST_SELF, ST_EMIT
	} state_t;

	state_t           state_q, ret_q;
	logic [SW-1:0]    clr_q;
	logic [OP_W-1:0]  op_q;
	logic [SW-1:0]    slot_q;
	logic [PW-1:0]    limit_q;
	logic             market_q;
	logic [QTY_W-1:0] qty_q;
	logic [FW-1:0]    fills_q;
	logic             capped_q;
	logic [WW-1:0]    wait_q;
	logic [LW-1:0]    lvl_q;
	logic [PW-1:0]    bp_q;
	logic [SW-1:0]    maker_q;
	slot_rec_t        rec_q;
	logic [SW-1:0]    u_q;
	logic [LW-1:0]    ulvl_q;
	lvl_rec_t         lrec_q;
	event_t           ev_q;
	event_t           out_q;
	logic             out_valid_q;

	// memory ports
	logic      s_we;
	logic [SW-1:0] s_waddr, s_raddr;
	slot_rec_t s_wdata, s_rdata;
	logic      l_we;
	logic [LW-1:0] l_waddr, l_raddr;
	lvl_rec_t  l_wdata, l_rdata;

	// level cell chain
	flag_wr_t               fw;
	best_t                  chain [NCELLS+1];
	best_t                  best;
	logic [CELL_LEVELS-1:0] buy_flags  [NCELLS];
	logic [CELL_LEVELS-1:0] sell_flags [NCELLS];

	// decode and datapath
	logic [SW-1:0]    in_slot;
	logic             in_bad;
	logic [PW-1:0]    in_limit;
	logic             opp_found;
	logic [PW-1:0]    opp_price;
	logic             crosses;
	slot_rec_t        mk_upd;
	logic [QTY_W-1:0] trade;
	logic [QTY_W-1:0] mk_left;
	logic [QTY_W-1:0] qty_left;
	logic             is_head, is_tail;
	slot_rec_t        self_rec;
	logic [LW-1:0]    own_lvl;
	logic [CIW-1:0]   own_cell;
	logic             own_nonempty;
	logic             out_free;

	function automatic logic [LW-1:0] lvl_of(logic side, logic [PW-1:0] price);
		lvl_of = side ? LW'(PRICE_LEVELS) + LW'(price) : LW'(price);
	endfunction

	function automatic event_t mk_ev(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
			logic [PRICE_W-1:0] price, logic [QTY_W-1:0] tq, logic [QTY_W-1:0] rq,
			logic last);
		event_t e;
		e.event_kind         = kind;
		e.maker_id           = id;
		e.trade_price        = price;
		e.trade_quantity     = tq;
		e.remaining_quantity = rq;
		e.last_event         = last;
		return e;
	endfunction

	lobm_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	lobm_ram #(.WIDTH($bits(lvl_rec_t)), .DEPTH(NLEVELS)) u_level_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	assign chain[0] = '0;
	for (genvar c = 0; c < NCELLS; c++) begin : g_cell
		lobm_level_cell #(.IDX(c)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr         (fw),
			.best_in    (chain[c]),
			.best_out   (chain[c+1]),
			.buy_flags  (buy_flags[c]),
			.sell_flags (sell_flags[c])
		);
	end
	assign best = chain[NCELLS];

	// input decode, prices beyond the book saturate to the top level
	assign in_slot  = SW'(orders.data.order_id);
	assign in_bad   = (orders.data.opcode == OP_BAD) ||
		(32'(orders.data.order_id) >= ORDER_SLOTS);
	assign in_limit = (32'(orders.data.limit_price) >= PRICE_LEVELS) ?
		PW'(PRICE_LEVELS - 1) : PW'(orders.data.limit_price);

	// buy takes the lowest sell level, sell takes the highest buy level
	assign opp_found = (op_q == OP_BUY) ? best.sell_found : best.buy_found;
	assign opp_price = (op_q == OP_BUY) ? PW'(best.sell_price) : PW'(best.buy_price);
	assign crosses   = market_q ||
		((op_q == OP_BUY) ? (opp_price <= limit_q) : (opp_price >= limit_q));

	assign trade    = (s_rdata.qty < qty_q) ? s_rdata.qty : qty_q;
	assign mk_left  = s_rdata.qty - trade;
	assign qty_left = qty_q - trade;

	assign is_head = (l_rdata.head == u_q);
	assign is_tail = (l_rdata.tail == u_q);

	assign own_lvl      = lvl_of(op_q[0], limit_q);
	assign own_cell     = CIW'(LVL_PRICE_W'(limit_q) >> CELL_LW);
	assign own_nonempty = op_q[0] ? sell_flags[own_cell][limit_q[CELL_LW-1:0]] :
		buy_flags[own_cell][limit_q[CELL_LW-1:0]];

	always_comb begin
		self_rec       = '0;
		self_rec.live  = 1'b1;
		self_rec.side  = op_q[0];
		self_rec.price = limit_q;
		self_rec.qty   = qty_q;
		mk_upd         = s_rdata;
		mk_upd.qty     = mk_left;
	end

	assign out_free = !out_valid_q || events.ready;

	// memory and flag control per step
	always_comb begin
		s_we    = 1'b0;
		s_waddr = slot_q;
		s_wdata = rec_q;
		s_raddr = in_slot;
		l_we    = 1'b0;
		l_waddr = own_lvl;
		l_wdata = lrec_q;
		l_raddr = lvl_q;
		fw      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
			end
			ST_IDLE: s_raddr = in_slot;
			ST_MATCH_LVL: l_raddr = lvl_q;
			ST_MATCH_HEAD: s_raddr = l_rdata.head;
			ST_MATCH_TRADE: begin
				// partial fill keeps the maker in place with less quantity
				if (mk_left != '0) begin
					s_we    = 1'b1;
					s_waddr = maker_q;
					s_wdata = mk_upd;
				end
			end
			ST_UL_LVL: l_raddr = ulvl_q;
			ST_UL_CHK: begin
				priority if (is_head && is_tail) begin
					fw.en    = 1'b1;
					fw.side  = rec_q.side;
					fw.price = LVL_PRICE_W'(rec_q.price);
					fw.val   = 1'b0;
				end else if (is_head) begin
					l_we         = 1'b1;
					l_waddr      = ulvl_q;
					l_wdata.head = rec_q.next;
					l_wdata.tail = l_rdata.tail;
				end else if (is_tail) begin
					l_we         = 1'b1;
					l_waddr      = ulvl_q;
					l_wdata.head = l_rdata.head;
					l_wdata.tail = rec_q.prev;
				end else begin
					s_raddr = rec_q.prev;
				end
			end
			ST_UL_P: begin
				s_we         = 1'b1;
				s_waddr      = rec_q.prev;
				s_wdata      = s_rdata;
				s_wdata.next = rec_q.next;
				s_raddr      = rec_q.next;
			end
			ST_UL_N: begin
				s_we         = 1'b1;
				s_waddr      = rec_q.next;
				s_wdata      = s_rdata;
				s_wdata.prev = rec_q.prev;
			end
			ST_UL_SELF: begin
				s_we         = 1'b1;
				s_waddr      = u_q;
				s_wdata      = rec_q;
				s_wdata.live = 1'b0;
			end
			ST_REST: begin
				if (own_nonempty) begin
					l_raddr = own_lvl;
				end else begin
					// first order of an empty level
					s_we         = 1'b1;
					s_waddr      = slot_q;
					s_wdata      = self_rec;
					l_we         = 1'b1;
					l_waddr      = own_lvl;
					l_wdata.head = slot_q;
					l_wdata.tail = slot_q;
					fw.en        = 1'b1;
					fw.side      = op_q[0];
					fw.price     = LVL_PRICE_W'(limit_q);
					fw.val       = 1'b1;
				end
			end
			ST_REST_LVL: s_raddr = l_rdata.tail;
			ST_REST_T: begin
				s_we         = 1'b1;
				s_waddr      = lrec_q.tail;
				s_wdata      = s_rdata;
				s_wdata.next = slot_q;
			end
			ST_REST_SELF: begin
				s_we         = 1'b1;
				s_waddr      = slot_q;
				s_wdata      = self_rec;
				s_wdata.prev = lrec_q.tail;
				l_we         = 1'b1;
				l_waddr      = own_lvl;
				l_wdata.head = lrec_q.head;
				l_wdata.tail = slot_q;
			end
			default: ;
		endcase
	end

	// sequencer and event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ret_q       <= ST_IDLE;
			clr_q       <= '0;
			op_q        <= OP_BUY;
			slot_q      <= '0;
			limit_q     <= '0;
			market_q    <= 1'b0;
			qty_q       <= '0;
			fills_q     <= '0;
			capped_q    <= 1'b0;
			wait_q      <= '0;
			lvl_q       <= '0;
			bp_q        <= '0;
			maker_q     <= '0;
			rec_q       <= '0;
			u_q         <= '0;
			ulvl_q      <= '0;
			lrec_q      <= '0;
			ev_q        <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_q       <= ev_q;
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(ORDER_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (orders.valid) begin
						op_q     <= orders.data.opcode;
						slot_q   <= in_slot;
						limit_q  <= in_limit;
						market_q <= orders.data.is_market;
						qty_q    <= orders.data.order_quantity;
						if (in_bad) begin
							ev_q    <= mk_ev(EV_UNKNOWN, orders.data.order_id, '0, '0, '0, 1'b1);
							ret_q   <= ST_IDLE;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SELF_CHK;
						end
					end
				end
				ST_SELF_CHK: begin
					if (op_q == OP_CANCEL) begin
						if (!s_rdata.live) begin
							ev_q    <= mk_ev(EV_UNKNOWN, ID_W'(slot_q), '0, '0, '0, 1'b1);
							ret_q   <= ST_IDLE;
							state_q <= ST_EMIT;
						end else begin
							rec_q   <= s_rdata;
							u_q     <= slot_q;
							ulvl_q  <= lvl_of(s_rdata.side, s_rdata.price);
							ev_q    <= mk_ev(EV_CANCELLED, ID_W'(slot_q), '0, '0, '0, 1'b1);
							ret_q   <= ST_IDLE;
							state_q <= ST_UL_LVL;
						end
					end else if (s_rdata.live) begin
						ev_q    <= mk_ev(EV_DUPLICATE, ID_W'(slot_q), '0, '0, '0, 1'b1);
						ret_q   <= ST_IDLE;
						state_q <= ST_EMIT;
					end else begin
						fills_q  <= '0;
						capped_q <= 1'b0;
						wait_q   <= WW'(NCELLS);
						state_q  <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// wait until the chain has carried the latest flags to its end
					if (wait_q != '0) begin
						wait_q <= wait_q - 1'b1;
					end else if (qty_q == '0 || !opp_found || !crosses) begin
						state_q <= ST_CLOSE;
					end else if (fills_q == FW'(MAX_FILLS)) begin
						capped_q <= 1'b1;
						state_q  <= ST_CLOSE;
					end else begin
						lvl_q   <= lvl_of(~op_q[0], opp_price);
						bp_q    <= opp_price;
						state_q <= ST_MATCH_LVL;
					end
				end
				ST_MATCH_LVL: state_q <= ST_MATCH_HEAD;
				ST_MATCH_HEAD: begin
					maker_q <= l_rdata.head;
					state_q <= ST_MATCH_TRADE;
				end
				ST_MATCH_TRADE: begin
					qty_q   <= qty_left;
					fills_q <= fills_q + 1'b1;
					wait_q  <= WW'(NCELLS);
					ev_q    <= mk_ev(EV_FILL, ID_W'(maker_q), PRICE_W'(bp_q), trade, qty_left,
						1'b0);
					ret_q   <= (qty_left != '0) ? ST_SEARCH : ST_CLOSE;
					if (mk_left == '0) begin
						// maker used up: unlink it from its level
						rec_q   <= mk_upd;
						u_q     <= maker_q;
						ulvl_q  <= lvl_q;
						state_q <= ST_UL_LVL;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_UL_LVL: state_q <= ST_UL_CHK;
				ST_UL_CHK: state_q <= (!is_head && !is_tail) ? ST_UL_P : ST_UL_SELF;
				ST_UL_P: state_q <= ST_UL_N;
				ST_UL_N: state_q <= ST_UL_SELF;
				ST_UL_SELF: state_q <= ST_EMIT;
				ST_CLOSE: begin
					ret_q <= ST_IDLE;
					priority if (capped_q) begin
						ev_q    <= mk_ev(EV_CAP, ID_W'(slot_q), '0, '0, qty_q, 1'b1);
						state_q <= ST_EMIT;
					end else if (qty_q != '0 && !market_q) begin
						state_q <= ST_REST;
					end else begin
						ev_q    <= mk_ev(EV_DONE, ID_W'(slot_q), '0, '0, qty_q, 1'b1);
						state_q <= ST_EMIT;
					end
				end
				ST_REST: begin
					if (own_nonempty) begin
						state_q <= ST_REST_LVL;
					end else begin
						ev_q    <= mk_ev(EV_RESTED, ID_W'(slot_q), '0, '0, qty_q, 1'b1);
						state_q <= ST_EMIT;
					end
				end
				ST_REST_LVL: begin
					lrec_q  <= l_rdata;
					state_q <= ST_REST_T;
				end
				ST_REST_T: state_q <= ST_REST_SELF;
				ST_REST_SELF: begin
					ev_q    <= mk_ev(EV_RESTED, ID_W'(slot_q), '0, '0, qty_q, 1'b1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign orders.ready = (state_q == ST_IDLE);
	assign events.valid = out_valid_q;
	assign events.data  = out_q;

	`LOBM_ASSERT_IMP(a_fills_bounded, 1'b1, fills_q <= FW'(MAX_FILLS))
	`LOBM_ASSERT_IMP(a_idle_holds_final, (state_q == ST_IDLE && out_valid_q), out_q.last_event)
	`LOBM_ASSERT_IMP(a_fill_nonzero, (out_valid_q && out_q.event_kind == EV_FILL),
		(out_q.trade_quantity != '0 && !out_q.last_event))
	`LOBM_ASSERT_NEXT(a_emit_loads, (state_q == ST_EMIT && out_free), out_valid_q)

endmodule

### rtl/lobm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/lobm_level_cell.sv
// one cell of the price level chain: sixteen buy and sixteen sell nonempty flags
// depends on lobm_pkg
module lobm_level_cell import lobm_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  flag_wr_t               wr,
	input  best_t                  best_in,
	output best_t                  best_out,
	output logic [CELL_LEVELS-1:0] buy_flags,
	output logic [CELL_LEVELS-1:0] sell_flags
);
	logic [CELL_LEVELS-1:0] buy_q;
	logic [CELL_LEVELS-1:0] sell_q;
	best_t                  local_b;
	best_t                  best_q;
	logic                   hit;

	assign hit = wr.en &&
		(wr.price[LVL_PRICE_W-1:CELL_LW] == (LVL_PRICE_W-CELL_LW)'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buy_q  <= '0;
			sell_q <= '0;
		end else if (hit) begin
			if (wr.side) begin
				sell_q[wr.price[CELL_LW-1:0]] <= wr.val;
			end else begin
				buy_q[wr.price[CELL_LW-1:0]] <= wr.val;
			end
		end
	end

	// highest buy and lowest sell inside this cell
	always_comb begin
		local_b = '0;
		for (int j = 0; j < CELL_LEVELS; j++) begin
			if (buy_q[j]) begin
				local_b.buy_found = 1'b1;
				local_b.buy_price = {(LVL_PRICE_W-CELL_LW)'(IDX), CELL_LW'(j)};
			end
		end
		for (int j = CELL_LEVELS - 1; j >= 0; j--) begin
			if (sell_q[j]) begin
				local_b.sell_found = 1'b1;
				local_b.sell_price = {(LVL_PRICE_W-CELL_LW)'(IDX), CELL_LW'(j)};
			end
		end
	end

	// cells run from low to high prices: higher buy wins, lower sell wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			if (local_b.buy_found) begin
				best_q.buy_found <= 1'b1;
				best_q.buy_price <= local_b.buy_price;
			end else begin
				best_q.buy_found <= best_in.buy_found;
				best_q.buy_price <= best_in.buy_price;
			end
			if (best_in.sell_found) begin
				best_q.sell_found <= 1'b1;
				best_q.sell_price <= best_in.sell_price;
			end else begin
				best_q.sell_found <= local_b.sell_found;
				best_q.sell_price <= local_b.sell_price;
			end
		end
	end

	assign best_out   = best_q;
	assign buy_flags  = buy_q;
	assign sell_flags = sell_q;
endmodule

### bench/tb_limit_order_book_matcher.sv
// self-checking bench for the order book matcher: directed and random orders, random stalls
// depends on lobm_pkg, lobm_stream_if and the limit_order_book_matcher rtl
`timescale 1ns / 100ps

module tb_limit_order_book_matcher import lobm_pkg::*;;

	localparam int SLOTS  = 1024;
	localparam int LEVELS = 256;
	localparam int FILL_CAP = 63;
	localparam int STALL_LIMIT = 20000;

	// a scoreboard that keeps its own copy of the book and predicts events
	class book_scoreboard;
		bit        live [SLOTS];
		bit [31:0] qty [SLOTS];
		bit [7:0]  price [SLOTS];
		bit        side [SLOTS];
		bit [9:0]  nxt [SLOTS];
		bit [9:0]  prv [SLOTS];
		bit [9:0]  head [2*LEVELS];
		bit [9:0]  tail [2*LEVELS];
		bit        busy [2*LEVELS];
		event_t    pending [$];
		int        errors;
		int        fills;
		int        caps;
		int        rests;
		int        cancels;

		function void push(logic [KIND_W-1:0] k, int id, int pr, bit [31:0] tq,
				bit [31:0] rq, bit last);
			event_t e;
			e.event_kind = k;
			e.maker_id = ID_W'(id);
			e.trade_price = PRICE_W'(pr);
			e.trade_quantity = tq;
			e.remaining_quantity = rq;
			e.last_event = last;
			pending.insert(pending.size(), e);
		endfunction

		function void unlink(int lvl, int id);
			int p;
			int n;
			p = int'(prv[id]);
			n = int'(nxt[id]);
			if (head[lvl] == id && tail[lvl] == id) begin
				busy[lvl] = 0;
			end else if (head[lvl] == id) begin
				head[lvl] = 10'(n);
			end else if (tail[lvl] == id) begin
				tail[lvl] = 10'(p);
			end else begin
				nxt[p] = 10'(n);
				prv[n] = 10'(p);
			end
		endfunction

		function int best_opposite(bit s);
			if (s == 0) begin
				for (int p = 0; p < LEVELS; p++)
					if (busy[LEVELS + p]) return p;
			end else begin
				for (int p = LEVELS - 1; p >= 0; p--)
					if (busy[p]) return p;
			end
			return -1;
		endfunction

		// note an accepted order and queue the events it should cause
		function void note_order(order_t o);
			int id;
			int lim;
			int n;
			int bp;
			int lvl;
			int mk;
			bit [31:0] q;
			bit [31:0] tr;
			bit capped;
			id = int'(o.order_id);
			lim = int'(o.limit_price);
			q = o.order_quantity;
			n = 0;
			capped = 0;
			if (o.opcode == OP_BAD) begin
				push(EV_UNKNOWN, id, 0, 0, 0, 1);
				return;
			end
			if (o.opcode == OP_CANCEL) begin
				if (!live[id]) begin
					push(EV_UNKNOWN, id, 0, 0, 0, 1);
				end else begin
					unlink(side[id] * LEVELS + price[id], id);
					live[id] = 0;
					cancels++;
					push(EV_CANCELLED, id, 0, 0, 0, 1);
				end
				return;
			end
			if (live[id]) begin
				push(EV_DUPLICATE, id, 0, 0, 0, 1);
				return;
			end
			while (q != 0) begin
				bp = best_opposite(o.opcode[0]);
				if (bp < 0) break;
				if (!o.is_market && (o.opcode == OP_BUY ? bp > lim : bp < lim)) break;
				if (n >= FILL_CAP) begin
					capped = 1;
					break;
				end
				lvl = (o.opcode == OP_BUY ? LEVELS : 0) + bp;
				mk = int'(head[lvl]);
				tr = qty[mk] < q ? qty[mk] : q;
				qty[mk] -= tr;
				q -= tr;
				if (qty[mk] == 0) begin
					unlink(lvl, mk);
					live[mk] = 0;
				end
				push(EV_FILL, mk, bp, tr, q, 0);
				n++;
				fills++;
			end
			if (capped) begin
				caps++;
				push(EV_CAP, id, 0, 0, q, 1);
			end else if (q != 0 && !o.is_market) begin
				lvl = o.opcode[0] * LEVELS + lim;
				live[id] = 1;
				qty[id] = q;
				price[id] = 8'(lim);
				side[id] = o.opcode[0];
				if (!busy[lvl]) begin
					head[lvl] = 10'(id);
					tail[lvl] = 10'(id);
					busy[lvl] = 1;
				end else begin
					nxt[tail[lvl]] = 10'(id);
					prv[id] = tail[lvl];
					tail[lvl] = 10'(id);
				end
				rests++;
				push(EV_RESTED, id, 0, 0, q, 1);
			end else begin
				push(EV_DONE, id, 0, 0, q, 1);
			end
		endfunction

		function void check_event(event_t got);
			event_t want;
			if (pending.size() == 0) begin
				$error("unexpected event kind %0d id %0d", got.event_kind, got.maker_id);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.event_kind !== want.event_kind) begin
				$error("event_kind expected %0d actual %0d", want.event_kind, got.event_kind);
				errors++;
			end
			if (got.maker_id !== want.maker_id) begin
				$error("maker_id expected %0d actual %0d", want.maker_id, got.maker_id);
				errors++;
			end
			if (got.trade_price !== want.trade_price) begin
				$error("trade_price expected %0d actual %0d", want.trade_price,
					got.trade_price);
				errors++;
			end
			if (got.trade_quantity !== want.trade_quantity) begin
				$error("trade_quantity expected %0d actual %0d", want.trade_quantity,
					got.trade_quantity);
				errors++;
			end
			if (got.remaining_quantity !== want.remaining_quantity) begin
				$error("remaining_quantity expected %0d actual %0d",
					want.remaining_quantity, got.remaining_quantity);
				errors++;
			end
			if (got.last_event !== want.last_event) begin
				$error("last_event expected %0d actual %0d", want.last_event,
					got.last_event);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	lobm_stream_if #(.data_t(order_t)) orders ();
	lobm_stream_if #(.data_t(event_t)) events ();

	limit_order_book_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.orders(orders),
		.events(events)
	);

	always #4 clk = ~clk;

	book_scoreboard sb = new();
	int  idle_cycles;
	int  orders_sent;
	int  events_seen;
	bit  hold_events;    // long receiver hold-off, set by the stimulus
	bit  quiet_rx;       // stretch with no receiver stalls
	int  rx_hold_len;

	initial begin
		orders.valid = 0;
		orders.data = '0;
		events.ready = 0;
	end

	// watchdog: cycles with no beat on either side; the reset sweep fits easily
	always @(posedge clk) begin
		if ((orders.valid && orders.ready) || (events.valid && events.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random waits per beat, long hold-off on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_events) begin
				events.ready <= 0;
				for (int i = 0; i < rx_hold_len; i++) @(posedge clk);
				hold_events = 0;
			end
			w = quiet_rx ? 0 : $urandom_range(0, 12);
			if (w > 0) begin
				events.ready <= 0;
				repeat (w) @(posedge clk);
			end
			events.ready <= 1;
			@(posedge clk);
			while (!events.valid) @(posedge clk);
			sb.check_event(events.data);
			events_seen++;
		end
	end

	// one order beat, with a random gap ahead of it unless no_gap is set; valid stays up between beats only without a gap
	task automatic send_order(input order_t o, input bit no_gap);
		int w;
		w = no_gap ? 0 : $urandom_range(0, 12);
		if (w > 0) begin
			orders.valid <= 0;
			repeat (w) @(posedge clk);
		end
		orders.data <= o;
		orders.valid <= 1;
		@(posedge clk);
		while (!orders.ready) @(posedge clk);
		sb.note_order(o);
		orders_sent++;
	endtask

	function automatic order_t make(logic [1:0] op, int id, int pr, bit mkt, bit [31:0] q);
		order_t o;
		o.opcode = op;
		o.order_id = ID_W'(id);
		o.limit_price = PRICE_W'(pr);
		o.is_market = mkt;
		o.order_quantity = q;
		return o;
	endfunction

	// mostly well-formed flow near a mid price, with noise mixed in
	function automatic order_t random_order();
		int r;
		int id;
		int pr;
		bit [31:0] q;
		r = $urandom_range(0, 99);
		id = $urandom_range(0, 63);
		if ($urandom_range(0, 19) == 0) id = $urandom_range(0, SLOTS - 1);
		pr = 120 + $urandom_range(0, 16) - 8;
		if ($urandom_range(0, 15) == 0) pr = $urandom_range(0, 255);
		q = $urandom_range(1, 50);
		if ($urandom_range(0, 15) == 0) q = $urandom();
		if ($urandom_range(0, 40) == 0) q = 0;
		if (r < 2) return make(OP_BAD, id, pr, 1'($urandom_range(0, 1)), $urandom());
		if (r < 20) return make(OP_CANCEL, id, $urandom_range(0, 255),
			1'($urandom_range(0, 1)), $urandom());
		return make(r < 60 ? OP_BUY : OP_SELL, id, pr, $urandom_range(0, 9) == 0, q);
	endfunction

	initial begin
		hold_events = 0;
		quiet_rx = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: price extremes, every opcode, rejects and zero quantity
		send_order(make(OP_BUY, 0, 0, 0, 32'd10), 0);
		send_order(make(OP_SELL, 1023, 255, 0, 32'hFFFF_FFFF), 0);
		send_order(make(OP_BUY, 0, 5, 0, 32'd3), 0);           // duplicate id
		send_order(make(OP_CANCEL, 7, 0, 0, 0), 0);            // unknown cancel
		send_order(make(OP_BAD, 1023, 255, 1, 32'hFFFF_FFFF), 0);
		send_order(make(OP_BUY, 2, 255, 1, 0), 0);             // zero quantity
		send_order(make(OP_BUY, 3, 255, 0, 32'd5), 0);         // crosses the sell
		send_order(make(OP_SELL, 4, 0, 1, 32'd20), 0);         // market sell, remainder drop
		send_order(make(OP_CANCEL, 1023, 0, 0, 0), 0);
		send_order(make(OP_SELL, 5, 100, 0, 32'd7), 0);
		send_order(make(OP_SELL, 6, 100, 0, 32'd9), 0);
		send_order(make(OP_SELL, 8, 100, 0, 32'd4), 0);
		send_order(make(OP_CANCEL, 6, 0, 0, 0), 0);            // middle of a level
		send_order(make(OP_BUY, 9, 100, 1, 32'd100), 0);       // market buy sweeps level
		// fill cap: 64 small sells, then one buy that would take them all
		for (int i = 0; i < 64; i++)
			send_order(make(OP_SELL, 100 + i, 200 + (i % 4), 0, 32'd1), 1);
		send_order(make(OP_BUY, 10, 255, 0, 32'd1000), 0);
		send_order(make(OP_SELL, 11, 0, 1, 32'hFFFF_FFFF), 0); // clear the buy side
		send_order(make(OP_BUY, 12, 255, 1, 32'hFFFF_FFFF), 0);

		// pressure: receiver stops while orders keep coming
		rx_hold_len = 400;
		hold_events = 1;
		for (int i = 0; i < 30; i++) send_order(random_order(), 1);

		for (int i = 0; i < 360; i++) begin
			quiet_rx = (i >= 200 && i < 260);
			send_order(random_order(), (i >= 300 && i < 340));
		end
		orders.valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("run covered %0d orders, %0d events: %0d fills, %0d caps, %0d rests, %0d cancels",
			orders_sent, events_seen, sb.fills, sb.caps, sb.rests, sb.cancels);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/lobm_pkg.sv
rtl/lobm_stream_if.sv
rtl/lobm_ram.sv
rtl/lobm_level_cell.sv
rtl/limit_order_book_matcher.sv
bench/tb_limit_order_book_matcher.sv
